/* design/lsra_pkg.sv */
`default_nettype none
package lsra_pkg;
   localparam int NUM_REGS   = 32;
   localparam int MAX_ACTIVE = 32;
   localparam int POINT_BITS = 16;

   localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);
   localparam int USED_W = $clog2(NUM_REGS + 1);
   localparam int SUM_W  = USED_W + 5;

   typedef logic [NUM_REGS-1:0]   regs_type;
   typedef logic [POINT_BITS-1:0] point_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [USED_W-1:0]     used_type;

   typedef enum logic [1:0] {
      OUT_ALLOC  = 2'd0,
      OUT_SPILL  = 2'd1,
      OUT_VICTIM = 2'd2,
      OUT_ERROR  = 2'd3
   } outcome_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic expire;
      logic pick;
      logic insert;
      logic spill;
      logic error;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic expire_hit;
      logic fits;
      logic list_empty;
      logic pick_done;
   } status_type;
endpackage
`default_nettype wire

/* design/lsra_ctrl.sv */
`default_nettype none
module lsra_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire lsra_pkg::status_type status,
   output lsra_pkg::cmd_type        cmd
);
   import lsra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_DECIDE,
      ST_PICK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EXPIRE;
         end
         ST_EXPIRE: begin
            cmd.expire = status.expire_hit;
            if (!status.expire_hit) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.fits) begin
               state_in = ST_PICK;
            end else if (status.list_empty) begin
               cmd.error = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.spill = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_PICK: begin
            if (status.pick_done) begin
               cmd.insert = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.pick = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.emit = !rsp_valid_ff || !rsp_stall;
            if (cmd.emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

/* design/lsra_dp.sv */
`default_nettype none
module lsra_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lsra_pkg::cmd_type   cmd,
   output lsra_pkg::status_type     status,
   input  wire logic [15:0]         req_interval_id,
   input  wire logic [15:0]         req_start_point,
   input  wire logic [15:0]         req_end_point,
   input  wire logic [3:0]          req_regs_needed,
   input  wire logic                req_new_function,
   output logic [1:0]               rsp_outcome,
   output logic [31:0]              rsp_reg_mask,
   output logic [15:0]              rsp_victim_id,
   output logic [5:0]               rsp_regs_in_use,
   output logic                     rsp_any_spill
);
   import lsra_pkg::*;

   // Sorted active list, one cell per entry.
   point_type end_ff  [MAX_ACTIVE];
   logic [15:0] id_ff [MAX_ACTIVE];
   regs_type  regs_ff [MAX_ACTIVE];

   cnt_type     cnt_ff;
   regs_type    free_ff;
   used_type    used_ff;
   logic        spill_ff;

   logic [15:0] in_id_ff;
   point_type   in_start_ff, in_end_ff;
   logic [3:0]  in_need_ff;
   logic [3:0]  pick_cnt_ff;
   regs_type    given_ff;
   logic [15:0] victim_ff;
   outcome_type outcome_ff;

   logic [1:0]  out_outcome_ff;
   logic [31:0] out_mask_ff;
   logic [15:0] out_victim_ff;
   logic [5:0]  out_used_ff;
   logic        out_spill_ff;

   point_type   last_end;
   logic [15:0] last_id;
   regs_type    last_regs;
   logic        take_victim, ins_en;
   cnt_type     eff_cnt;
   regs_type    ins_regs, low_free;
   logic [MAX_ACTIVE-1:0] le, prev_le;

   function automatic point_type to_point(logic [15:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[POINT_BITS-1:0];
   endfunction

   always_comb begin
      last_end  = '0;
      last_id   = '0;
      last_regs = '0;
      for (int k = 0; k < MAX_ACTIVE; k++) begin
         if (CNT_W'(k + 1) == cnt_ff) begin
            last_end  = last_end  | end_ff[k];
            last_id   = last_id   | id_ff[k];
            last_regs = last_regs | regs_ff[k];
         end
      end
   end

   assign take_victim = cmd.spill && (in_end_ff < last_end);
   assign ins_en      = cmd.insert || take_victim;
   assign eff_cnt     = cmd.insert ? cnt_ff : cnt_ff - CNT_W'(1);
   assign ins_regs    = cmd.insert ? given_ff : last_regs;
   assign low_free    = free_ff & (~free_ff + NUM_REGS'(1));

   for (genvar k = 0; k < MAX_ACTIVE; k++) begin : g_le
      assign le[k] = (CNT_W'(k) < eff_cnt) && (end_ff[k] <= in_end_ff);
      if (k == 0) begin : g_first
         assign prev_le[k] = 1'b1;
      end else begin : g_rest
         assign prev_le[k] = le[k-1];
      end
   end

   for (genvar k = 0; k < MAX_ACTIVE; k++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.expire) begin
            if (k < MAX_ACTIVE - 1) begin
               end_ff[k]  <= end_ff[(k + 1) % MAX_ACTIVE];
               id_ff[k]   <= id_ff[(k + 1) % MAX_ACTIVE];
               regs_ff[k] <= regs_ff[(k + 1) % MAX_ACTIVE];
            end
         end else if (ins_en && !le[k]) begin
            if (prev_le[k]) begin
               end_ff[k]  <= in_end_ff;
               id_ff[k]   <= in_id_ff;
               regs_ff[k] <= ins_regs;
            end else begin
               end_ff[k]  <= end_ff[(k + MAX_ACTIVE - 1) % MAX_ACTIVE];
               id_ff[k]   <= id_ff[(k + MAX_ACTIVE - 1) % MAX_ACTIVE];
               regs_ff[k] <= regs_ff[(k + MAX_ACTIVE - 1) % MAX_ACTIVE];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         free_ff  <= '1;
         used_ff  <= '0;
         spill_ff <= 1'b0;
      end else begin
         if (cmd.load && req_new_function) begin
            cnt_ff   <= '0;
            free_ff  <= '1;
            used_ff  <= '0;
            spill_ff <= 1'b0;
         end
         if (cmd.expire) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            free_ff <= free_ff | regs_ff[0];
            used_ff <= used_ff - USED_W'($countones(regs_ff[0]));
         end
         if (cmd.pick) begin
            free_ff <= free_ff & ~low_free;
            used_ff <= used_ff + USED_W'(1);
         end
         if (cmd.insert) cnt_ff <= cnt_ff + CNT_W'(1);
         if (cmd.spill) spill_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_id_ff    <= req_interval_id;
         in_start_ff <= to_point(req_start_point);
         in_end_ff   <= to_point(req_end_point);
         in_need_ff  <= req_regs_needed;
         pick_cnt_ff <= '0;
         given_ff    <= '0;
         victim_ff   <= '0;
      end
      if (cmd.pick) begin
         given_ff    <= given_ff | low_free;
         pick_cnt_ff <= pick_cnt_ff + 4'd1;
      end
      if (cmd.insert) outcome_ff <= OUT_ALLOC;
      if (cmd.error) outcome_ff <= OUT_ERROR;
      if (cmd.spill) begin
         if (take_victim) begin
            given_ff   <= last_regs;
            victim_ff  <= last_id;
            outcome_ff <= OUT_VICTIM;
         end else begin
            outcome_ff <= OUT_SPILL;
         end
      end
      if (cmd.emit) begin
         out_outcome_ff <= outcome_ff;
         out_mask_ff    <= given_ff;
         out_victim_ff  <= victim_ff;
         out_used_ff    <= 6'(8'(used_ff));
         out_spill_ff   <= spill_ff;
      end
   end

   assign status.expire_hit = (cnt_ff != '0) && (end_ff[0] < in_start_ff);
   assign status.fits       = (SUM_W'(used_ff) + SUM_W'(in_need_ff) <= SUM_W'(NUM_REGS))
                              && (cnt_ff < CNT_W'(MAX_ACTIVE));
   assign status.list_empty = (cnt_ff == '0);
   assign status.pick_done  = (pick_cnt_ff == in_need_ff);

   assign rsp_outcome     = out_outcome_ff;
   assign rsp_reg_mask    = out_mask_ff;
   assign rsp_victim_id   = out_victim_ff;
   assign rsp_regs_in_use = out_used_ff;
   assign rsp_any_spill   = out_spill_ff;
endmodule
`default_nettype wire

/* design/linear_scan_register_allocator.sv */
`default_nettype none
// Linear-scan register allocator. Live intervals come in by start point, one
// item at a time; each gives exactly one result item carrying the outcome
// (allocated, self spilled, took a victim's registers, or error), the mask of
// pool registers granted, the victim id, the registers in use afterwards and
// a sticky spill flag for the current function. An allocated item keeps the
// block busy while it retires the active intervals that end before its start
// (one per cycle, popped from the front of the sorted list), takes the
// registers it asks for (the lowest free register is taken one per cycle)
// and inserts itself; a spill or an error skips the picking step, and a spill
// that takes a victim's registers puts the new interval in the victim's place.
// The finish step waits for as long as an earlier result is still held by a
// stalled receiver. The active list is a row of cells that insert in sorted
// order in parallel. A finished result sits in an output register, so the
// next item is taken while it waits to drain.
module linear_scan_register_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_interval_id,
   input  wire logic [15:0] req_start_point,
   input  wire logic [15:0] req_end_point,
   input  wire logic [3:0]  req_regs_needed,
   input  wire logic        req_new_function,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_outcome,
   output logic [31:0]      rsp_reg_mask,
   output logic [15:0]      rsp_victim_id,
   output logic [5:0]       rsp_regs_in_use,
   output logic             rsp_any_spill
);
   import lsra_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences expiry, the fit decision, picking, insertion and the result hand-off.
   lsra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the active list, the free mask and the result.
   lsra_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_interval_id  (req_interval_id),
      .req_start_point  (req_start_point),
      .req_end_point    (req_end_point),
      .req_regs_needed  (req_regs_needed),
      .req_new_function (req_new_function),
      .rsp_outcome      (rsp_outcome),
      .rsp_reg_mask     (rsp_reg_mask),
      .rsp_victim_id    (rsp_victim_id),
      .rsp_regs_in_use  (rsp_regs_in_use),
      .rsp_any_spill    (rsp_any_spill)
   );

   // An error result never grants registers.
   a_error_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_ERROR) |-> (rsp_reg_mask == '0))
      else $error("error item carries a register mask");

   // Only a victim result names a victim.
   a_victim_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != OUT_VICTIM) |-> (rsp_victim_id == '0))
      else $error("victim id set without a victim");

   // Any spill outcome must raise the sticky flag.
   a_spill_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_outcome == OUT_SPILL) || (rsp_outcome == OUT_VICTIM))
      |-> rsp_any_spill)
      else $error("spill reported without sticky flag");

   // The pool can never be overcommitted.
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (7'(rsp_regs_in_use) <= 7'(NUM_REGS)))
      else $error("registers in use exceed the pool");
endmodule
`default_nettype wire
